@@ sv/ust_pkg.sv @@
// ----------------------------------------------------------------------------
// ust_pkg
// Shared types and constants for the UDP port socket table: transaction
// payloads, status and function codes, and the token that travels the chain.
// ----------------------------------------------------------------------------
package ust_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int MAX_ENTRIES       = 64;
    localparam int IDX_W             = 6;      // holds any index below MAX_ENTRIES
    localparam logic [15:0] EPH_LOW_RST  = 16'd49152;
    localparam logic [15:0] EPH_HIGH_RST = 16'd65535;

    typedef enum logic [2:0] {
        FN_OPEN    = 3'd0,
        FN_CLOSE   = 3'd1,
        FN_BIND    = 3'd2,
        FN_DELIVER = 3'd3,
        FN_SEND    = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_NOT_OPEN  = 3'd2,
        ST_CLASH     = 3'd3,
        ST_FULL      = 3'd4,
        ST_NO_MATCH  = 3'd5,
        ST_NO_IFACE  = 3'd6
    } status_t;

    localparam logic CFG_EPH_LOW  = 1'b0;
    localparam logic CFG_EPH_HIGH = 1'b1;

    typedef struct packed {
        logic [2:0]  func;
        logic [4:0]  socket_index;
        logic [3:0]  iface_id;
        logic [15:0] port_number;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  entry_index;
        logic [15:0] source_port;
        logic [3:0]  send_iface;
    } out_t;

    // Search kind carried by a chain token
    typedef enum logic [1:0] {
        MODE_FREE  = 2'd0,     // first unused entry
        MODE_MATCH = 2'd1,     // first used entry reachable at port/iface
        MODE_CLASH = 2'd2      // first other used entry overlapping port/iface
    } mode_t;

    typedef struct packed {
        logic             valid;
        mode_t            mode;
        logic [IDX_W-1:0] idx;
        logic [3:0]       iface;
        logic [15:0]      port;
        logic             found;
        logic [IDX_W-1:0] hit_idx;
        logic             tgt_used;
        logic [3:0]       tgt_iface;
        logic [15:0]      tgt_port;
    } tok_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             used;
        logic [3:0]       iface;
        logic [15:0]      port;
    } wr_t;

endpackage

@@ sv/udp_port_socket_table.sv @@
// ----------------------------------------------------------------------------
// udp_port_socket_table
// Socket table for UDP demultiplexing: open, close, bind, deliver lookup and
// source-port assignment over a chain of entry cells.
// ----------------------------------------------------------------------------
// Flow: a rejected index or unknown function skips the chain; a table
//   operation sends one token down the chain of N = TABLE_ENTRIES cells, one
//   cell per cycle; a send that searches a source port then streams up to N+2
//   candidate ports into the chain one per cycle and lets them drain.
// Throughput: one transaction in flight; the next input is taken once the
//   result sits in the output register.
// Reset: clears every entry, the output register and loads the ephemeral
//   range 49152..65535.
// ----------------------------------------------------------------------------
module udp_port_socket_table #(
    parameter int TABLE_ENTRIES = ust_pkg::TABLE_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ust_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output ust_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [15:0]   cfg_data
);
    import ust_pkg::*;

    // Candidate budget: port 0 plus every port held by another entry
    localparam int CAND_MAX = TABLE_ENTRIES + 2;
    localparam int CNT_W    = $clog2(CAND_MAX + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EPH,
        S_RESP
    } state_t;

    state_t      state_reg;
    in_t         req_reg;
    out_t        res_reg;
    out_t        out_reg;
    logic        out_valid_reg;
    wr_t         wr_reg;            // en marks a pending table write
    logic [15:0] eph_low_reg;
    logic [15:0] eph_high_reg;
    logic [3:0]  use_if_reg;
    logic [3:0]  tgt_iface_reg;
    logic [15:0] cand_reg;
    logic [CNT_W-1:0] inj_cnt_reg;
    logic [CNT_W-1:0] fly_cnt_reg;
    logic [CNT_W-1:0] fly_cnt_next;
    logic        inj_on_reg;
    logic        pfound_reg;
    logic [15:0] pport_reg;

    tok_t        chain [0:TABLE_ENTRIES];
    tok_t        tok_head;
    tok_t        tok_end;
    wr_t         wr_bus;

    logic        in_acc;
    logic        slot_free;
    logic        bad_idx;
    logic        needs_idx;
    logic        go_scan;
    logic        inj_last;

    // Scan decision
    out_t        dec_res;
    wr_t         dec_wr;
    logic        dec_eph;
    logic [3:0]  dec_use_if;

    // Early reply and search outcome
    out_t        rej_res;
    out_t        eph_res;
    wr_t         eph_wr;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign tok_end   = chain[TABLE_ENTRIES];

    assign bad_idx   = ({2'b00, in_data.socket_index} >= 7'(TABLE_ENTRIES));
    always_comb
    begin
        case (func_t'(in_data.func))
            FN_CLOSE, FN_BIND, FN_SEND: needs_idx = 1'b1;
            default:                    needs_idx = 1'b0;
        endcase
    end
    assign go_scan = in_acc && (in_data.func <= FN_SEND) && !(needs_idx && bad_idx);

    // Reply for a transaction rejected before any table access
    always_comb
    begin
        rej_res        = '0;
        rej_res.status = (in_data.func > FN_SEND) ? ST_NO_MATCH : ST_BAD_INDEX;
    end

    // Token injected at the head: one request token, or a stream of candidates
    always_comb
    begin
        tok_head = '0;
        if (state_reg == S_EPH)
        begin
            tok_head.valid = inj_on_reg;
            tok_head.mode  = MODE_MATCH;
            tok_head.iface = use_if_reg;
            tok_head.port  = cand_reg;
        end
        else
        begin
            tok_head.valid = go_scan;
            tok_head.idx   = IDX_W'(in_data.socket_index);
            tok_head.iface = in_data.iface_id;
            tok_head.port  = in_data.port_number;
            case (func_t'(in_data.func))
                FN_OPEN: tok_head.mode = MODE_FREE;
                FN_BIND: tok_head.mode = MODE_CLASH;
                default: tok_head.mode = MODE_MATCH;
            endcase
        end
    end

    assign chain[0] = tok_head;

    // Write broadcast: commit the pending update as the result is released
    always_comb
    begin
        wr_bus    = wr_reg;
        wr_bus.en = wr_reg.en && (state_reg == S_RESP) && slot_free;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            ust_cell #(
                .IDX (g)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .wr      (wr_bus),
                .tok_in  (chain[g]),
                .tok_out (chain[g+1])
            );
        end
    endgenerate

    // Decide the outcome of a single request token leaving the chain
    always_comb
    begin
        dec_res    = '0;
        dec_wr     = '0;
        dec_eph    = 1'b0;
        dec_use_if = (tok_end.tgt_iface != 4'd0) ? tok_end.tgt_iface : req_reg.iface_id;
        dec_wr.idx = IDX_W'(req_reg.socket_index);
        case (func_t'(req_reg.func))
            FN_OPEN:
            begin
                if (tok_end.found)
                begin
                    dec_res.status      = ST_OK;
                    dec_res.entry_index = tok_end.hit_idx[3:0];
                    dec_wr.en           = 1'b1;
                    dec_wr.idx          = tok_end.hit_idx;
                    dec_wr.used         = 1'b1;
                end
                else
                begin
                    dec_res.status = ST_FULL;
                end
            end
            FN_CLOSE:
            begin
                if (!tok_end.tgt_used)
                begin
                    dec_res.status = ST_NOT_OPEN;
                end
                else
                begin
                    dec_res.status = ST_OK;
                    dec_wr.en      = 1'b1;
                end
            end
            FN_BIND:
            begin
                if (!tok_end.tgt_used)
                begin
                    dec_res.status = ST_NOT_OPEN;
                end
                else if (tok_end.found)
                begin
                    dec_res.status = ST_CLASH;
                end
                else
                begin
                    dec_res.status = ST_OK;
                    dec_wr.en      = 1'b1;
                    dec_wr.used    = 1'b1;
                    dec_wr.iface   = req_reg.iface_id;
                    dec_wr.port    = req_reg.port_number;
                end
            end
            FN_DELIVER:
            begin
                if (tok_end.found)
                begin
                    dec_res.status      = ST_OK;
                    dec_res.entry_index = tok_end.hit_idx[3:0];
                end
                else
                begin
                    dec_res.status = ST_NO_MATCH;
                end
            end
            FN_SEND:
            begin
                if (!tok_end.tgt_used)
                begin
                    dec_res.status = ST_NOT_OPEN;
                end
                else if (dec_use_if == 4'd0)
                begin
                    dec_res.status = ST_NO_IFACE;
                end
                else if (tok_end.tgt_port != 16'd0)
                begin
                    dec_res.status      = ST_OK;
                    dec_res.source_port = tok_end.tgt_port;
                    dec_res.send_iface  = dec_use_if;
                end
                else
                begin
                    // Unbound: search the ephemeral range
                    dec_res.status = ST_NO_IFACE;
                    dec_eph        = 1'b1;
                end
            end
            default:
            begin
                dec_res.status = ST_NO_MATCH;
            end
        endcase
    end

    // Result and table update once a free source port has been found
    always_comb
    begin
        eph_res             = res_reg;
        eph_res.status      = ST_OK;
        eph_res.source_port = pport_reg;
        eph_res.send_iface  = use_if_reg;
        eph_wr              = '0;
        eph_wr.en           = 1'b1;
        eph_wr.idx          = IDX_W'(req_reg.socket_index);
        eph_wr.used         = 1'b1;
        eph_wr.iface        = tgt_iface_reg;
        eph_wr.port         = pport_reg;
    end

    // Stop injecting at the range end or once the candidate budget is spent
    assign inj_last = (cand_reg == eph_high_reg) || (inj_cnt_reg == CNT_W'(CAND_MAX - 1));

    always_comb
    begin
        fly_cnt_next = fly_cnt_reg;
        if (inj_on_reg && !tok_end.valid)
        begin
            fly_cnt_next = fly_cnt_reg + CNT_W'(1);
        end
        else if (!inj_on_reg && tok_end.valid)
        begin
            fly_cnt_next = fly_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            wr_reg        <= '0;
            eph_low_reg   <= EPH_LOW_RST;
            eph_high_reg  <= EPH_HIGH_RST;
            inj_on_reg    <= 1'b0;
            inj_cnt_reg   <= '0;
            fly_cnt_reg   <= '0;
            pfound_reg    <= 1'b0;
            req_reg       <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            use_if_reg    <= 4'd0;
            tgt_iface_reg <= 4'd0;
            cand_reg      <= 16'd0;
            pport_reg     <= 16'd0;
        end
        else
        begin
            // Configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_EPH_LOW:  eph_low_reg  <= cfg_data;
                    CFG_EPH_HIGH: eph_high_reg <= cfg_data;
                    default:      ;
                endcase
            end

            // Load a finished result, or drop the one the downstream side takes
            if ((state_reg == S_RESP) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        req_reg   <= in_data;
                        wr_reg.en <= 1'b0;
                        res_reg   <= rej_res;
                        if (go_scan)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_RESP;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (tok_end.valid)
                    begin
                        res_reg       <= dec_res;
                        wr_reg        <= dec_wr;
                        use_if_reg    <= dec_use_if;
                        tgt_iface_reg <= tok_end.tgt_iface;
                        cand_reg      <= eph_low_reg;
                        inj_cnt_reg   <= '0;
                        fly_cnt_reg   <= '0;
                        pfound_reg    <= 1'b0;
                        if (dec_eph && (eph_low_reg <= eph_high_reg))
                        begin
                            inj_on_reg <= 1'b1;
                            state_reg  <= S_EPH;
                        end
                        else
                        begin
                            state_reg <= S_RESP;
                        end
                    end
                end
                S_EPH:
                begin
                    // Advance the candidate stream
                    if (inj_on_reg)
                    begin
                        inj_cnt_reg <= inj_cnt_reg + CNT_W'(1);
                        if (inj_last)
                        begin
                            inj_on_reg <= 1'b0;
                        end
                        else
                        begin
                            cand_reg <= cand_reg + 16'd1;
                        end
                    end
                    fly_cnt_reg <= fly_cnt_next;

                    // Candidates return in order: keep the first free nonzero port
                    if (tok_end.valid && !pfound_reg && !tok_end.found &&
                        (tok_end.port != 16'd0))
                    begin
                        pfound_reg <= 1'b1;
                        pport_reg  <= tok_end.port;
                    end

                    if (!inj_on_reg && (fly_cnt_reg == '0))
                    begin
                        if (pfound_reg)
                        begin
                            res_reg <= eph_res;
                            wr_reg  <= eph_wr;
                        end
                        state_reg <= S_RESP;
                    end
                end
                S_RESP:
                begin
                    // Hold until the output register is free, then release
                    if (slot_free)
                    begin
                        out_reg   <= res_reg;
                        wr_reg.en <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/ust_cell.sv @@
// ----------------------------------------------------------------------------
// ust_cell
// One socket table entry plus one token stage. Compares the passing token
// against the entry, records the first hit and the addressed entry's fields.
// ----------------------------------------------------------------------------
module ust_cell #(
    parameter int IDX = 0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  ust_pkg::wr_t  wr,
    input  ust_pkg::tok_t tok_in,
    output ust_pkg::tok_t tok_out
);
    import ust_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic        used_reg;
    logic [3:0]  iface_reg;
    logic [15:0] port_reg;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic        port_eq;
    logic        iface_ok;
    logic        hit;

    assign port_eq  = (port_reg == tok_in.port);
    assign iface_ok = (iface_reg == 4'd0) || (iface_reg == tok_in.iface);

    always_comb
    begin
        case (tok_in.mode)
            MODE_FREE:  hit = !used_reg;
            MODE_MATCH: hit = used_reg && port_eq && iface_ok;
            MODE_CLASH: hit = (tok_in.idx != MY_IDX) && used_reg && port_eq &&
                              (iface_ok || (tok_in.iface == 4'd0));
            default:    hit = 1'b0;
        endcase
    end

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.found && hit)
        begin
            tok_next.found   = 1'b1;
            tok_next.hit_idx = MY_IDX;
        end
        if (tok_in.idx == MY_IDX)
        begin
            tok_next.tgt_used  = used_reg;
            tok_next.tgt_iface = iface_reg;
            tok_next.tgt_port  = port_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            iface_reg <= 4'd0;
            port_reg  <= 16'd0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wr.en && (wr.idx == MY_IDX))
            begin
                used_reg  <= wr.used;
                iface_reg <= wr.iface;
                port_reg  <= wr.port;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ tb/sv/udp_port_socket_table_tb.sv @@
// ----------------------------------------------------------------------------
// udp_port_socket_table_tb
// Self-checking bench for the UDP socket table. A cycle-free predictor mirrors
// the entry table and the ephemeral range. It computes the reply of every
// accepted request transaction, and each reply transaction is checked field
// by field in order. Directed tests cover the corner cases first. Random
// socket traffic follows under several idling mixes and ephemeral ranges.
// ----------------------------------------------------------------------------
module udp_port_socket_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ust_pkg::*;

    localparam int TBL_N          = TABLE_ENTRIES_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 3 * TBL_N + 16;   // longest send search plus margin
    localparam int ITEMS_PER_MIX  = 215;
    localparam int HOLD_OFF_LEN   = 500;
    localparam int MAX_REPORTS    = 10;

    // Function codes the block does not know; they must answer "no match"
    localparam logic [2:0] FN_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] FN_UNKNOWN_HI = 3'd7;

    // Small port pool shared by binds and deliveries so that clashes happen
    localparam logic [15:0] POOL_BASE = 16'd5000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_t         in_data;
    logic        out_valid;
    logic        out_stall;
    out_t        out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // Predictor state: one copy of the socket table and the ephemeral range
    logic        sock_used  [TBL_N];
    logic [3:0]  sock_iface [TBL_N];
    logic [15:0] sock_port  [TBL_N];
    logic [15:0] eph_lo;
    logic [15:0] eph_hi;

    out_t awaited_replies[$];
    out_t head_reply;
    int   mismatch_count = 0;
    int   idle_pct       = 0;
    int   stall_pct      = 0;
    int   hold_cycles    = 0;
    int   quiet_cycles   = 0;

    udp_port_socket_table #(
        .TABLE_ENTRIES (TBL_N)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // True when port p is already held by an entry reachable on interface ifc
    function automatic bit port_held(logic [15:0] p, logic [3:0] ifc);
        for (int k = 0; k < TBL_N; k++)
        begin
            if (sock_used[k] && sock_port[k] == p &&
                (sock_iface[k] == 4'd0 || sock_iface[k] == ifc))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one request to the mirrored table and return the reply it earns
    function automatic out_t predict_socket_op(in_t op);
        out_t       r;
        int         idx;
        int         p;
        logic [3:0] use_if;
        r      = '0;
        r.status = ST_OK;
        idx    = int'(op.socket_index);
        case (op.func)
            FN_OPEN:
            begin
                r.status = ST_FULL;
                for (int k = 0; k < TBL_N; k++)
                begin
                    if (!sock_used[k])
                    begin
                        sock_used[k]  = 1'b1;
                        r.status      = ST_OK;
                        r.entry_index = 4'(k);
                        break;
                    end
                end
            end
            FN_DELIVER:
            begin
                // Unbound but used entries hold port zero and can match it
                r.status = ST_NO_MATCH;
                for (int k = 0; k < TBL_N; k++)
                begin
                    if (sock_used[k] && sock_port[k] == op.port_number &&
                        (sock_iface[k] == 4'd0 || sock_iface[k] == op.iface_id))
                    begin
                        r.status      = ST_OK;
                        r.entry_index = 4'(k);
                        break;
                    end
                end
            end
            FN_CLOSE, FN_BIND, FN_SEND:
            begin
                if (idx >= TBL_N)
                    r.status = ST_BAD_INDEX;
                else if (!sock_used[idx])
                    r.status = ST_NOT_OPEN;
                else if (op.func == FN_CLOSE)
                begin
                    sock_used[idx]  = 1'b0;
                    sock_iface[idx] = 4'd0;
                    sock_port[idx]  = 16'd0;
                end
                else if (op.func == FN_BIND)
                begin
                    // Interface zero overlaps everything, on either side
                    for (int k = 0; k < TBL_N; k++)
                    begin
                        if (k != idx && sock_used[k] && sock_port[k] == op.port_number &&
                            (op.iface_id == 4'd0 || sock_iface[k] == 4'd0 ||
                             sock_iface[k] == op.iface_id))
                        begin
                            r.status = ST_CLASH;
                            break;
                        end
                    end
                    if (r.status == ST_OK)
                    begin
                        sock_iface[idx] = op.iface_id;
                        sock_port[idx]  = op.port_number;
                    end
                end
                else
                begin
                    // Send: bound interface wins over the routed one
                    use_if = (sock_iface[idx] != 4'd0) ? sock_iface[idx] : op.iface_id;
                    if (use_if == 4'd0)
                        r.status = ST_NO_IFACE;
                    else
                    begin
                        // Lowest free ephemeral port, never port zero; empty if lo > hi
                        if (sock_port[idx] == 16'd0)
                        begin
                            for (p = int'(eph_lo); p <= int'(eph_hi); p++)
                            begin
                                if (p != 0 && !port_held(16'(p), use_if))
                                begin
                                    sock_port[idx] = 16'(p);
                                    break;
                                end
                            end
                        end
                        if (sock_port[idx] == 16'd0)
                            r.status = ST_NO_IFACE;
                        else
                        begin
                            r.source_port = sock_port[idx];
                            r.send_iface  = use_if;
                        end
                    end
                end
            end
            default:
                r.status = ST_NO_MATCH;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    function automatic in_t socket_op(logic [2:0] fn, logic [4:0] idx, logic [3:0] ifc,
                                      logic [15:0] port);
        in_t op;
        op.func         = fn;
        op.socket_index = idx;
        op.iface_id     = ifc;
        op.port_number  = port;
        return op;
    endfunction

    // Offer one request transaction; predict its reply once it is accepted.
    // Keep valid high across back-to-back requests, drop it only for a gap.
    task automatic issue_socket_op(input in_t op);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= op;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        awaited_replies.push_back(predict_socket_op(op));
    endtask

    // Drop valid and wait until every predicted reply has come back
    task automatic drain_replies();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_eph_reg(input logic ridx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= ridx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (ridx == CFG_EPH_LOW)
            eph_lo = val;
        else
            eph_hi = val;
    endtask

    // Reprogram the ephemeral range; only legal with the table idle
    task automatic set_eph_range(input logic [15:0] lo, input logic [15:0] hi);
        drain_replies();
        write_eph_reg(CFG_EPH_LOW, lo);
        write_eph_reg(CFG_EPH_HIGH, hi);
    endtask

    // Mostly address entries that are open, sometimes any index up to 31
    function automatic logic [4:0] pick_socket();
        int k;
        if ($urandom_range(9) == 0)
            return 5'($urandom_range(31));
        for (int t = 0; t < 4; t++)
        begin
            k = $urandom_range(TBL_N - 1);
            if (sock_used[k])
                return 5'(k);
        end
        return 5'($urandom_range(TBL_N - 1));
    endfunction

    // Favor ports from the shared pool, live in the table or near the ephemeral base
    function automatic logic [15:0] pick_port();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(65535));
            4:       return eph_lo + 16'($urandom_range(3));
            5, 6, 7: return POOL_BASE + 16'($urandom_range(5));
            default: return sock_port[$urandom_range(TBL_N - 1)];
        endcase
    endfunction

    function automatic in_t random_socket_op();
        int         sel;
        logic [2:0] fn;
        logic [3:0] ifc;
        sel = $urandom_range(99);
        if (sel < 4)
            fn = 3'($urandom_range(int'(FN_UNKNOWN_LO), int'(FN_UNKNOWN_HI)));
        else if (sel < 20)
            fn = FN_OPEN;
        else if (sel < 38)
            fn = FN_CLOSE;
        else if (sel < 60)
            fn = FN_BIND;
        else if (sel < 80)
            fn = FN_DELIVER;
        else
            fn = FN_SEND;
        ifc = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(15));
        return socket_op(fn, pick_socket(), ifc, pick_port());
    endfunction

    // ------------------------------------------------------------------------
    // Reply side: stall generator and checker
    // ------------------------------------------------------------------------

    // A requested hold-off takes precedence over random stalling
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall   <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic log_mismatch(input string why, input out_t want, input out_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("mismatch (%s): expected st=%0d idx=%0d sport=%0d if=%0d",
                     why, want.status, want.entry_index, want.source_port, want.send_iface);
            $display("    got st=%0d idx=%0d sport=%0d if=%0d",
                     got.status, got.entry_index, got.source_port, got.send_iface);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_replies.size() == 0)
                log_mismatch("reply with none pending", '0, out_data);
            else
            begin
                head_reply = awaited_replies.pop_front();
                if (out_data.status !== head_reply.status ||
                    out_data.entry_index !== head_reply.entry_index ||
                    out_data.source_port !== head_reply.source_port ||
                    out_data.send_iface !== head_reply.send_iface)
                    log_mismatch("field", head_reply, out_data);
            end
        end
    end

    // Watchdog: end the run after too many cycles with no transaction at all
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
        $display("udp_port_socket_table_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner cases on a freshly reset table
    task automatic test_socket_basics();
        issue_socket_op(socket_op(FN_DELIVER, 5'd0, 4'd0, 16'd0));        // empty table
        issue_socket_op(socket_op(FN_CLOSE, 5'd0, 4'd0, 16'd0));          // not open
        issue_socket_op(socket_op(FN_BIND, 5'd31, 4'd15, 16'hFFFF));      // index out of range
        issue_socket_op(socket_op(FN_SEND, 5'(TBL_N), 4'd1, 16'd0));      // first bad index
        issue_socket_op(socket_op(FN_UNKNOWN_LO, 5'd3, 4'd3, 16'd7));
        issue_socket_op(socket_op(FN_UNKNOWN_HI, 5'd31, 4'd15, 16'hFFFF));
        issue_socket_op(socket_op(FN_OPEN, 5'd0, 4'd0, 16'd0));
        issue_socket_op(socket_op(FN_OPEN, 5'd0, 4'd0, 16'd0));
        issue_socket_op(socket_op(FN_SEND, 5'd0, 4'd0, 16'd0));           // no interface at all
        issue_socket_op(socket_op(FN_DELIVER, 5'd0, 4'd3, 16'd0));        // hits an unbound entry
        issue_socket_op(socket_op(FN_SEND, 5'd0, 4'd15, 16'd0));          // takes first ephemeral
        issue_socket_op(socket_op(FN_BIND, 5'd1, 4'd15, EPH_LOW_RST));    // clashes with entry 0
        issue_socket_op(socket_op(FN_BIND, 5'd1, 4'd0, 16'hFFFF));
        issue_socket_op(socket_op(FN_DELIVER, 5'd0, 4'd9, 16'hFFFF));     // any-interface match
        issue_socket_op(socket_op(FN_BIND, 5'd0, 4'd15, 16'd0));          // bind to port zero
        issue_socket_op(socket_op(FN_SEND, 5'd0, 4'd2, 16'd0));           // bound interface wins
        issue_socket_op(socket_op(FN_CLOSE, 5'd1, 4'd0, 16'd0));
        issue_socket_op(socket_op(FN_SEND, 5'd1, 4'd3, 16'd0));           // closed again
    endtask

    // Fill every entry, overflow once, then free and reclaim the last one
    task automatic test_table_full();
        int open_count;
        open_count = 0;
        for (int k = 0; k < TBL_N; k++)
            if (!sock_used[k])
                open_count++;
        repeat (open_count + 1)
            issue_socket_op(socket_op(FN_OPEN, 5'd0, 4'd0, 16'd0));
        issue_socket_op(socket_op(FN_CLOSE, 5'(TBL_N - 1), 4'd0, 16'd0));
        issue_socket_op(socket_op(FN_OPEN, 5'd0, 4'd0, 16'd0));
    endtask

    // Ephemeral range at its extremes: single top port, empty range, port one
    task automatic test_source_port_range();
        issue_socket_op(socket_op(FN_CLOSE, 5'd2, 4'd0, 16'd0));
        issue_socket_op(socket_op(FN_CLOSE, 5'd3, 4'd0, 16'd0));
        set_eph_range(16'hFFFF, 16'hFFFF);
        issue_socket_op(socket_op(FN_OPEN, 5'd0, 4'd0, 16'd0));
        issue_socket_op(socket_op(FN_SEND, 5'd2, 4'd4, 16'd0));
        issue_socket_op(socket_op(FN_OPEN, 5'd0, 4'd0, 16'd0));
        issue_socket_op(socket_op(FN_SEND, 5'd3, 4'd4, 16'd0));           // range used up
        set_eph_range(16'd300, 16'd200);
        issue_socket_op(socket_op(FN_SEND, 5'd3, 4'd9, 16'd0));           // empty range
        set_eph_range(16'd1, 16'd1);
        issue_socket_op(socket_op(FN_SEND, 5'd3, 4'd9, 16'd0));
        set_eph_range(16'd1, 16'hFFFF);
    endtask

    // Hold the reply side off for a long stretch while requests keep coming
    task automatic test_reply_hold_off();
        drain_replies();
        idle_pct    = 0;
        stall_pct   = 0;
        hold_cycles = HOLD_OFF_LEN;
        repeat (8)
            issue_socket_op(random_socket_op());
    endtask

    // Random socket traffic under each idling mix and a spread of ranges
    task automatic test_random_traffic();
        logic [15:0] range_lo [8];
        logic [15:0] range_hi [8];
        int          mix_idle  [4];
        int          mix_stall [4];
        int          sel;
        range_lo  = '{EPH_LOW_RST, 16'd1, POOL_BASE, 16'hFFFF,
                      16'd1, 16'd300, 16'd65530, 16'd5002};
        range_hi  = '{EPH_HIGH_RST, 16'hFFFF, 16'd5003, 16'hFFFF,
                      16'd1, 16'd200, 16'hFFFF, 16'd5010};
        mix_idle  = '{0, 69, 0, 8};
        mix_stall = '{0, 0, 69, 8};
        for (int m = 0; m < 4; m++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                sel = 2 * m + h;
                set_eph_range(range_lo[sel], range_hi[sel]);
                idle_pct  = mix_idle[m];
                stall_pct = mix_stall[m];
                repeat (ITEMS_PER_MIX)
                    issue_socket_op(random_socket_op());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_EPH_LOW;
        cfg_data  = '0;
        for (int k = 0; k < TBL_N; k++)
        begin
            sock_used[k]  = 1'b0;
            sock_iface[k] = 4'd0;
            sock_port[k]  = 16'd0;
        end
        eph_lo = EPH_LOW_RST;
        eph_hi = EPH_HIGH_RST;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_socket_basics();
        test_table_full();
        test_source_port_range();
        test_reply_hold_off();
        test_random_traffic();

        // Let the last replies arrive, then allow for the longest send search
        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        mismatch_count = mismatch_count + awaited_replies.size();
        if (mismatch_count == 0)
            $display("udp_port_socket_table_tb OK");
        else
            $display("udp_port_socket_table_tb NOT OK");
        $finish;
    end

endmodule
